// ----- rtl/rljf_pkg.sv -----
package rljf_pkg;

  typedef enum logic [1:0] {
    MODE_TICK   = 2'd0,
    MODE_JOIN   = 2'd1,
    MODE_FETCH  = 2'd2,
    MODE_WAKE   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    PH_START      = 4'd0,
    PH_FORMING    = 4'd1,
    PH_JSEND      = 4'd2,
    PH_JWAIT      = 4'd3,
    PH_JRESP      = 4'd4,
    PH_IDLE       = 4'd5,
    PH_SLEEPWAIT  = 4'd6,
    PH_SLEEPING   = 4'd7,
    PH_ERROR      = 4'd8,
    PH_RSEND      = 4'd9,
    PH_RSTATUS    = 4'd10,
    PH_RWAIT      = 4'd11,
    PH_RESETSTART = 4'd12,
    PH_RESETWAIT  = 4'd13,
    PH_WAKING     = 4'd14
  } phase_t;

  localparam logic [2:0] FK_NONE   = 3'd0;
  localparam logic [2:0] FK_CMD    = 3'd1;
  localparam logic [2:0] FK_MODEM  = 3'd2;
  localparam logic [2:0] FK_TXSTAT = 3'd3;
  localparam logic [2:0] FK_DATA   = 3'd4;

  localparam logic [3:0] ST_OK          = 4'd0;
  localparam logic [3:0] ST_NEW_MSG     = 4'd1;
  localparam logic [3:0] ST_ASSOC_FAIL  = 4'd2;
  localparam logic [3:0] ST_JOIN_UNDEL  = 4'd3;
  localparam logic [3:0] ST_JOIN_TMO    = 4'd4;
  localparam logic [3:0] ST_JOIN_OK     = 4'd5;
  localparam logic [3:0] ST_JOIN_BAD    = 4'd6;
  localparam logic [3:0] ST_SLEEPING    = 4'd7;
  localparam logic [3:0] ST_ERROR       = 4'd8;
  localparam logic [3:0] ST_UPD_UNDEL   = 4'd9;
  localparam logic [3:0] ST_UPD_TMO     = 4'd10;

  localparam logic [1:0] SEND_NONE  = 2'd0;
  localparam logic [1:0] SEND_RESET = 2'd1;
  localparam logic [1:0] SEND_JOIN  = 2'd2;
  localparam logic [1:0] SEND_REQ   = 2'd3;

  localparam logic [7:0] JOIN_ACK = 8'h4B;

  localparam logic [1:0] REG_ASSOC   = 2'd0;
  localparam logic [1:0] REG_REPLY   = 2'd1;
  localparam logic [1:0] REG_WINDOW  = 2'd2;
  localparam logic [1:0] REG_RETRIES = 2'd3;

  localparam logic [15:0] ASSOC_RESET   = 16'd10000;
  localparam logic [15:0] REPLY_RESET   = 16'd5000;
  localparam logic [15:0] WINDOW_RESET  = 16'd1000;
  localparam logic [2:0]  RETRIES_RESET = 3'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [2:0]  frame_kind;
    logic        frame_flag;
    logic [7:0]  data_length;
    logic [7:0]  first_byte;
    logic [7:0]  last_byte;
    logic        radio_awake;
    logic [31:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [3:0] status_code;
    logic [1:0] send_frame;
    logic       sleep_request;
    logic [3:0] current_state;
  } result_t;

endpackage

// ----- rtl/radio_link_join_fetch_controller.sv -----
// radio end-device link controller: resets the radio, waits for network
// association, sends a join and expects 'K', then idles, fetching messages
// with 'R' (bounded retries on timeout) or sleeping and waking through the
// sleep pin handshake. every accepted item (tick or request) gives exactly one
// result item in the next cycle: status, frame to send, sleep pin level and the
// state after the item. one item is accepted per clock cycle while results are
// taken; the figure is set by the single state register update, which is a
// 32-bit add and window compare plus the state decode. an item can be accepted
// while the previous result waits, as long as that result is taken in the same
// cycle. the configuration registers sit on a 4-register apb port at byte
// offsets 0, 4, 8, 12 and should only be written while no result is pending.
module radio_link_join_fetch_controller (
  input  logic              clk,
  input  logic              rst,
  // item channel
  input  logic              item_valid,
  output logic              item_ready,
  input  rljf_pkg::item_t   item,
  // result channel
  output logic              result_valid,
  input  logic              result_ready,
  output rljf_pkg::result_t result,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // configuration registers
  logic [15:0] assoc_timeout_ms;
  logic [15:0] reply_timeout_ms;
  logic [15:0] timeout_window_ms;
  logic [2:0]  max_retries;

  // controller state
  rljf_pkg::phase_t phase, phase_next;
  logic [31:0] deadline, deadline_next;
  logic        deadline_armed, deadline_armed_next;
  logic [2:0]  retry_count, retry_count_next;
  logic        update_pending, update_pending_next;
  logic        wake_pending, wake_pending_next;
  logic        rejoin_pending, rejoin_pending_next;
  logic        sleep_pin_level, sleep_pin_level_next;

  logic [3:0]  status;
  logic [1:0]  send;
  logic        accept;
  logic        cfg_write;
  logic [32:0] window_end;
  logic        window_wraps;
  logic        expired;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // apb register write
  always_ff @(posedge clk) begin
    if (rst) begin
      assoc_timeout_ms  <= rljf_pkg::ASSOC_RESET;
      reply_timeout_ms  <= rljf_pkg::REPLY_RESET;
      timeout_window_ms <= rljf_pkg::WINDOW_RESET;
      max_retries       <= rljf_pkg::RETRIES_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        rljf_pkg::REG_ASSOC:   assoc_timeout_ms  <= pwdata[15:0];
        rljf_pkg::REG_REPLY:   reply_timeout_ms  <= pwdata[15:0];
        rljf_pkg::REG_WINDOW:  timeout_window_ms <= pwdata[15:0];
        rljf_pkg::REG_RETRIES: max_retries       <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  // apb register read
  always_comb begin
    unique case (paddr[3:2])
      rljf_pkg::REG_ASSOC:   prdata = {16'd0, assoc_timeout_ms};
      rljf_pkg::REG_REPLY:   prdata = {16'd0, reply_timeout_ms};
      rljf_pkg::REG_WINDOW:  prdata = {16'd0, timeout_window_ms};
      rljf_pkg::REG_RETRIES: prdata = {29'd0, max_retries};
      default:               prdata = 32'd0;
    endcase
  end

  // one result slot: accept whenever it is empty or being drained
  assign item_ready = !result_valid || result_ready;
  assign accept     = item_valid && item_ready;

  // timeout only inside (deadline, deadline + window), wrapping mod 2^32
  assign window_end   = {1'b0, deadline} + {17'd0, timeout_window_ms};
  assign window_wraps = window_end[32];
  always_comb begin
    if (!deadline_armed) begin
      expired = 1'b0;
    end else if (window_wraps) begin
      expired = (item.now_ms > deadline) || (item.now_ms < window_end[31:0]);
    end else begin
      expired = (item.now_ms > deadline) && (item.now_ms < window_end[31:0]);
    end
  end

  // sequence step for one item
  always_comb begin
    phase_next           = phase;
    deadline_next        = deadline;
    deadline_armed_next  = deadline_armed;
    retry_count_next     = retry_count;
    update_pending_next  = update_pending;
    wake_pending_next    = wake_pending;
    rejoin_pending_next  = rejoin_pending;
    sleep_pin_level_next = sleep_pin_level;
    status               = rljf_pkg::ST_OK;
    send                 = rljf_pkg::SEND_NONE;

    unique case (rljf_pkg::mode_t'(item.mode))
      rljf_pkg::MODE_JOIN: begin
        // a join while asleep is held until the radio is woken
        if (phase == rljf_pkg::PH_SLEEPWAIT || phase == rljf_pkg::PH_SLEEPING) begin
          rejoin_pending_next = 1'b1;
        end else begin
          phase_next = rljf_pkg::PH_RESETSTART;
        end
      end
      rljf_pkg::MODE_FETCH: begin
        wake_pending_next   = 1'b1;
        update_pending_next = 1'b1;
      end
      rljf_pkg::MODE_WAKE: begin
        wake_pending_next = 1'b1;
      end
      default: begin
        unique case (phase)
          rljf_pkg::PH_START: begin
            update_pending_next = 1'b0;
            wake_pending_next   = 1'b0;
            deadline_next       = item.now_ms + {16'd0, assoc_timeout_ms};
            deadline_armed_next = 1'b1;
            phase_next          = rljf_pkg::PH_FORMING;
          end
          rljf_pkg::PH_FORMING: begin
            if (expired) begin
              phase_next = rljf_pkg::PH_ERROR;
              status     = rljf_pkg::ST_ASSOC_FAIL;
            end else if (item.frame_kind == rljf_pkg::FK_MODEM && item.frame_flag) begin
              deadline_armed_next = 1'b0;
              phase_next          = rljf_pkg::PH_JSEND;
            end
          end
          rljf_pkg::PH_JSEND: begin
            send       = rljf_pkg::SEND_JOIN;
            phase_next = rljf_pkg::PH_JWAIT;
          end
          rljf_pkg::PH_JWAIT: begin
            if (item.frame_kind == rljf_pkg::FK_TXSTAT) begin
              if (item.frame_flag) begin
                deadline_next       = item.now_ms + {16'd0, reply_timeout_ms};
                deadline_armed_next = 1'b1;
                phase_next          = rljf_pkg::PH_JRESP;
              end else begin
                phase_next = rljf_pkg::PH_ERROR;
                status     = rljf_pkg::ST_JOIN_UNDEL;
              end
            end
          end
          rljf_pkg::PH_JRESP: begin
            if (expired) begin
              deadline_armed_next = 1'b0;
              phase_next          = rljf_pkg::PH_ERROR;
              status              = rljf_pkg::ST_JOIN_TMO;
            end else if (item.frame_kind == rljf_pkg::FK_DATA) begin
              if (item.data_length == 8'd1 && item.first_byte == rljf_pkg::JOIN_ACK) begin
                deadline_armed_next = 1'b0;
                phase_next          = rljf_pkg::PH_IDLE;
                status              = rljf_pkg::ST_JOIN_OK;
              end else begin
                phase_next = rljf_pkg::PH_ERROR;
                status     = rljf_pkg::ST_JOIN_BAD;
              end
            end
          end
          rljf_pkg::PH_IDLE: begin
            if (update_pending) begin
              update_pending_next = 1'b0;
              phase_next          = rljf_pkg::PH_RSEND;
            end else begin
              sleep_pin_level_next = 1'b1;
              wake_pending_next    = 1'b0;
              phase_next           = rljf_pkg::PH_SLEEPWAIT;
            end
          end
          rljf_pkg::PH_SLEEPWAIT: begin
            if (item.frame_kind == rljf_pkg::FK_NONE && !item.radio_awake) begin
              phase_next = rljf_pkg::PH_SLEEPING;
              status     = rljf_pkg::ST_SLEEPING;
            end
          end
          rljf_pkg::PH_SLEEPING: begin
            if (rejoin_pending || wake_pending) begin
              sleep_pin_level_next = 1'b0;
              phase_next           = rljf_pkg::PH_WAKING;
            end
            status = rljf_pkg::ST_SLEEPING;
          end
          rljf_pkg::PH_WAKING: begin
            if (item.radio_awake) begin
              phase_next = rejoin_pending ? rljf_pkg::PH_RESETSTART : rljf_pkg::PH_IDLE;
            end else begin
              status = rljf_pkg::ST_SLEEPING;
            end
          end
          rljf_pkg::PH_RSEND: begin
            send       = rljf_pkg::SEND_REQ;
            phase_next = rljf_pkg::PH_RSTATUS;
          end
          rljf_pkg::PH_RSTATUS: begin
            if (item.frame_kind == rljf_pkg::FK_TXSTAT) begin
              if (item.frame_flag) begin
                deadline_next       = item.now_ms + {16'd0, reply_timeout_ms};
                deadline_armed_next = 1'b1;
                phase_next          = rljf_pkg::PH_RWAIT;
              end else begin
                phase_next = rljf_pkg::PH_ERROR;
                status     = rljf_pkg::ST_UPD_UNDEL;
              end
            end
          end
          rljf_pkg::PH_RWAIT: begin
            if (expired) begin
              deadline_armed_next = 1'b0;
              if (retry_count >= max_retries) begin
                retry_count_next = 3'd0;
                phase_next       = rljf_pkg::PH_ERROR;
                status           = rljf_pkg::ST_UPD_TMO;
              end else begin
                retry_count_next = retry_count + 3'd1;
                phase_next       = rljf_pkg::PH_RSEND;
              end
            end else if (item.frame_kind == rljf_pkg::FK_DATA) begin
              // a frame ending in a zero byte closes the message;
              // an empty frame never does and just re-arms the deadline
              if (item.data_length != 8'd0 && item.last_byte == 8'd0) begin
                deadline_armed_next = 1'b0;
                retry_count_next    = 3'd0;
                phase_next          = rljf_pkg::PH_IDLE;
                status              = rljf_pkg::ST_NEW_MSG;
              end else begin
                deadline_next       = item.now_ms + {16'd0, reply_timeout_ms};
                deadline_armed_next = 1'b1;
              end
            end
          end
          rljf_pkg::PH_RESETSTART: begin
            rejoin_pending_next = 1'b0;
            deadline_armed_next = 1'b0;
            send                = rljf_pkg::SEND_RESET;
            phase_next          = rljf_pkg::PH_RESETWAIT;
          end
          rljf_pkg::PH_RESETWAIT: begin
            if (item.frame_kind == rljf_pkg::FK_CMD && item.frame_flag) begin
              phase_next = rljf_pkg::PH_START;
            end
          end
          // error phase, and the unused code, hold until a join request
          default: begin
            status = rljf_pkg::ST_ERROR;
          end
        endcase
      end
    endcase
  end

  // controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= rljf_pkg::PH_START;
      deadline        <= 32'd0;
      deadline_armed  <= 1'b0;
      retry_count     <= 3'd0;
      update_pending  <= 1'b0;
      wake_pending    <= 1'b0;
      rejoin_pending  <= 1'b0;
      sleep_pin_level <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      deadline        <= deadline_next;
      deadline_armed  <= deadline_armed_next;
      retry_count     <= retry_count_next;
      update_pending  <= update_pending_next;
      wake_pending    <= wake_pending_next;
      rejoin_pending  <= rejoin_pending_next;
      sleep_pin_level <= sleep_pin_level_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.status_code   <= status;
      result.send_frame    <= send;
      result.sleep_request <= sleep_pin_level_next;
      result.current_state <= phase_next;
    end
  end

  // every accepted item leaves a result behind
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted item produced no result");

  // a pending result always reports the state it left behind
  a_state_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.current_state == phase))
    else $error("result state disagrees with controller state");

  a_sleep_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.sleep_request == sleep_pin_level))
    else $error("result sleep level disagrees with sleep pin register");

  // a frame is only sent on the step into a state that waits for its status
  a_send_state: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.send_frame != rljf_pkg::SEND_NONE) |->
      (result.current_state == rljf_pkg::PH_JWAIT ||
       result.current_state == rljf_pkg::PH_RSTATUS ||
       result.current_state == rljf_pkg::PH_RESETWAIT))
    else $error("frame sent from an unexpected state");

  // a timeout at the retry limit clears the count and enters the error phase
  a_retry_bound: assert property (@(posedge clk) disable iff (rst)
    (accept && phase == rljf_pkg::PH_RWAIT && expired &&
     item.mode == rljf_pkg::MODE_TICK && retry_count >= max_retries) |=>
      (retry_count == 3'd0 && phase == rljf_pkg::PH_ERROR))
    else $error("retry limit not enforced");

endmodule
